[src/vta_pkg.sv]
`default_nettype none
package vta_pkg;

    localparam int TRACKS          = 64;
    localparam int VOICE_LIMIT_MAX = 32;
    localparam int PRIORITY_LEVELS = 4;

    localparam int IDX_BITS   = 6;
    localparam int CNT_BITS   = 7;
    localparam int SOUND_BITS = 8;
    localparam int PRIO_BITS  = 2;
    localparam int LIMIT_BITS = 6;
    localparam int OP_BITS    = 3;
    localparam int STAT_BITS  = 3;
    localparam int USE_BITS   = 2;

    localparam logic [OP_BITS-1:0] OP_PLAY_SAMPLE = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PLAY_STREAM = 3'd1;
    localparam logic [OP_BITS-1:0] OP_RELEASE     = 3'd2;
    localparam logic [OP_BITS-1:0] OP_FINISHED    = 3'd3;
    localparam logic [OP_BITS-1:0] OP_STOP_SOUND  = 3'd4;

    localparam logic [STAT_BITS-1:0] ST_IDLE   = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_STOLEN = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_LIMIT  = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_NONE   = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_DONE   = 3'd4;

    localparam logic [USE_BITS-1:0] USE_NONE   = 2'd0;
    localparam logic [USE_BITS-1:0] USE_SAMPLE = 2'd1;
    localparam logic [USE_BITS-1:0] USE_STREAM = 2'd2;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [SOUND_BITS-1:0] sound;
        logic [PRIO_BITS-1:0]  prio;
        logic                  steal;
        logic [LIMIT_BITS-1:0] limit;
        logic [IDX_BITS-1:0]   target;
        logic                  scan;
    } cmd_t;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [IDX_BITS-1:0]   granted;
        logic [SOUND_BITS-1:0] evicted;
        logic [CNT_BITS-1:0]   stopped;
    } res_t;

endpackage
`default_nettype wire

[src/vta_front.sv]
`default_nettype none
module vta_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  op,
    input  wire logic [7:0]  sound_id,
    input  wire logic [1:0]  request_priority,
    input  wire logic        steal_allowed,
    input  wire logic [5:0]  voice_limit,
    input  wire logic [5:0]  target_track,
    output logic             cmd_valid,
    output vta_pkg::cmd_t    cmd,
    input  wire logic        cmd_take
);
    localparam logic [1:0] PRIO_MAX  = 2'(vta_pkg::PRIORITY_LEVELS - 1);
    localparam logic [5:0] LIMIT_MAX = 6'(vta_pkg::VOICE_LIMIT_MAX);

    vta_pkg::cmd_t q_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, wr_ptr_reg;
    vta_pkg::cmd_t in_cmd;
    logic       do_push, do_pop;

    // classify and clamp on the way in
    always_comb
    begin
        in_cmd.op     = op;
        in_cmd.sound  = sound_id;
        in_cmd.prio   = (32'(request_priority) >= vta_pkg::PRIORITY_LEVELS)
                        ? PRIO_MAX : request_priority;
        in_cmd.steal  = steal_allowed;
        in_cmd.limit  = (voice_limit == 6'd0) ? 6'd1 :
                        ((voice_limit > LIMIT_MAX) ? LIMIT_MAX : voice_limit);
        in_cmd.target = target_track;
        in_cmd.scan   = (op == vta_pkg::OP_PLAY_SAMPLE) || (op == vta_pkg::OP_PLAY_STREAM)
                        || (op == vta_pkg::OP_STOP_SOUND);
    end

    assign full      = count_reg[1];
    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end
endmodule
`default_nettype wire

[src/vta_back.sv]
`default_nettype none
module vta_back #(
    parameter int SEQ_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_wdata,
    input  wire logic          cmd_valid,
    input  wire vta_pkg::cmd_t cmd,
    output logic               cmd_take,
    output logic               res_valid,
    output vta_pkg::res_t      res,
    input  wire logic          res_pop
);
    localparam int TR = vta_pkg::TRACKS;
    localparam int IB = vta_pkg::IDX_BITS;
    localparam int CB = vta_pkg::CNT_BITS;
    localparam logic [CB-1:0] TR_CNT = CB'(TR);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [CB-1:0] track_count_reg;
    logic [SEQ_BITS-1:0] next_seq_reg;
    vta_pkg::cmd_t cmd_reg;

    logic [TR-1:0] playing_reg;
    logic [TR-1:0] valid_reg;
    logic [vta_pkg::SOUND_BITS-1:0] mem_sound [TR];
    logic [vta_pkg::PRIO_BITS-1:0]  mem_prio  [TR];
    logic [SEQ_BITS-1:0]            mem_seq   [TR];
    logic [vta_pkg::USE_BITS-1:0]   mem_use   [TR];

    logic [CB-1:0] addr_reg;
    logic          dv_reg;
    logic [IB-1:0] didx_reg;
    logic [vta_pkg::SOUND_BITS-1:0] rd_sound_reg;
    logic [vta_pkg::PRIO_BITS-1:0]  rd_prio_reg;
    logic [SEQ_BITS-1:0]            rd_seq_reg;
    logic [vta_pkg::USE_BITS-1:0]   rd_use_reg;

    logic [CB-1:0] count_reg;
    logic          idle_v_reg;
    logic [IB-1:0] idle_idx_reg;
    logic          cand_v_reg;
    logic [IB-1:0] cand_idx_reg;
    logic [vta_pkg::PRIO_BITS-1:0]  cand_prio_reg;
    logic [SEQ_BITS-1:0]            cand_seq_reg;
    logic [vta_pkg::SOUND_BITS-1:0] cand_sound_reg;

    logic res_valid_reg;
    vta_pkg::res_t res_reg;

    // entry seen this cycle; an entry never written reads as zero
    logic [vta_pkg::SOUND_BITS-1:0] e_sound;
    logic [vta_pkg::PRIO_BITS-1:0]  e_prio;
    logic [SEQ_BITS-1:0]            e_seq;
    logic [vta_pkg::USE_BITS-1:0]   e_use;
    logic e_play, e_en, e_steal_ok, take_cand, stop_hit;
    logic [CB-1:0] en_count;

    logic is_play, refused, grant, stolen, fin_go;
    logic [IB-1:0] grant_idx;
    vta_pkg::res_t fin_res;

    assign en_count = (track_count_reg > TR_CNT) ? TR_CNT : track_count_reg;

    always_comb
    begin
        e_sound = valid_reg[didx_reg] ? rd_sound_reg : '0;
        e_prio  = valid_reg[didx_reg] ? rd_prio_reg  : '0;
        e_seq   = valid_reg[didx_reg] ? rd_seq_reg   : '0;
        e_use   = valid_reg[didx_reg] ? rd_use_reg   : vta_pkg::USE_NONE;
        e_play  = playing_reg[didx_reg];
        e_en    = {1'b0, didx_reg} < en_count;
        e_steal_ok = e_en && e_play && cmd_reg.steal &&
                     !(cmd_reg.op == vta_pkg::OP_PLAY_STREAM && e_use == vta_pkg::USE_STREAM);
        take_cand = 1'b0;
        if (e_steal_ok)
        begin
            if (e_prio < cmd_reg.prio)
                take_cand = !cand_v_reg || (e_prio < cand_prio_reg) ||
                            (e_prio == cand_prio_reg && e_seq < cand_seq_reg);
            else if (e_prio == cmd_reg.prio && e_use != vta_pkg::USE_STREAM)
                take_cand = !cand_v_reg || (e_seq < cand_seq_reg);
        end
        stop_hit = (e_sound == cmd_reg.sound) && (e_use == vta_pkg::USE_SAMPLE);
    end

    always_comb
    begin
        is_play = (cmd_reg.op == vta_pkg::OP_PLAY_SAMPLE) ||
                  (cmd_reg.op == vta_pkg::OP_PLAY_STREAM);
        refused = (cmd_reg.op == vta_pkg::OP_PLAY_SAMPLE) &&
                  (count_reg >= {1'b0, cmd_reg.limit});
        stolen  = !idle_v_reg && cand_v_reg;
        grant   = is_play && !refused && (idle_v_reg || cand_v_reg);
        grant_idx = idle_v_reg ? idle_idx_reg : cand_idx_reg;
        fin_res.status  = vta_pkg::ST_DONE;
        fin_res.granted = '0;
        fin_res.evicted = '0;
        fin_res.stopped = '0;
        if (is_play)
        begin
            if (refused)
                fin_res.status = vta_pkg::ST_LIMIT;
            else if (!grant)
                fin_res.status = vta_pkg::ST_NONE;
            else
            begin
                fin_res.status  = stolen ? vta_pkg::ST_STOLEN : vta_pkg::ST_IDLE;
                fin_res.granted = grant_idx;
                fin_res.evicted = stolen ? cand_sound_reg : '0;
            end
        end
        else if (cmd_reg.op == vta_pkg::OP_STOP_SOUND)
            fin_res.stopped = count_reg;
        fin_go   = (state_reg == S_FIN) && (!res_valid_reg || res_pop);
        cmd_take = (state_reg == S_IDLE);
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            track_count_reg <= TR_CNT;
            next_seq_reg    <= SEQ_BITS'(1);
            playing_reg     <= '0;
            valid_reg       <= '0;
            res_valid_reg   <= 1'b0;
            dv_reg          <= 1'b0;
            addr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                track_count_reg <= cfg_wdata;
            if (res_pop && res_valid_reg && !fin_go)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        addr_reg  <= '0;
                        dv_reg    <= 1'b0;
                        state_reg <= cmd.scan ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN:
                begin
                    // advance one entry a cycle; the read data and its index are registered behind the address
                    if (addr_reg < TR_CNT)
                    begin
                        addr_reg <= addr_reg + CB'(1);
                        dv_reg   <= 1'b1;
                    end
                    else
                    begin
                        dv_reg <= 1'b0;
                        if (!dv_reg)
                            state_reg <= S_FIN;
                    end
                    if (dv_reg && cmd_reg.op == vta_pkg::OP_STOP_SOUND && stop_hit)
                        playing_reg[didx_reg] <= 1'b0;
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (grant)
                        begin
                            playing_reg[grant_idx] <= 1'b1;
                            valid_reg[grant_idx]   <= 1'b1;
                            next_seq_reg           <= next_seq_reg + SEQ_BITS'(1);
                        end
                        if (cmd_reg.op == vta_pkg::OP_RELEASE)
                        begin
                            playing_reg[cmd_reg.target] <= 1'b0;
                            valid_reg[cmd_reg.target]   <= 1'b0;
                        end
                        if (cmd_reg.op == vta_pkg::OP_FINISHED)
                            playing_reg[cmd_reg.target] <= 1'b0;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // payload: command hold, scan accumulators, table memory, result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            cmd_reg    <= cmd;
            count_reg  <= '0;
            idle_v_reg <= 1'b0;
            cand_v_reg <= 1'b0;
        end
        if (state_reg == S_SCAN)
        begin
            rd_sound_reg <= mem_sound[addr_reg[IB-1:0]];
            rd_prio_reg  <= mem_prio[addr_reg[IB-1:0]];
            rd_seq_reg   <= mem_seq[addr_reg[IB-1:0]];
            rd_use_reg   <= mem_use[addr_reg[IB-1:0]];
            didx_reg     <= addr_reg[IB-1:0];
            if (dv_reg)
            begin
                if (cmd_reg.op == vta_pkg::OP_STOP_SOUND)
                begin
                    if (stop_hit && e_play)
                        count_reg <= count_reg + CB'(1);
                end
                else
                begin
                    if (e_play && e_sound == cmd_reg.sound)
                        count_reg <= count_reg + CB'(1);
                    if (e_en && !e_play && !idle_v_reg)
                    begin
                        idle_v_reg   <= 1'b1;
                        idle_idx_reg <= didx_reg;
                    end
                    if (take_cand)
                    begin
                        cand_v_reg     <= 1'b1;
                        cand_idx_reg   <= didx_reg;
                        cand_prio_reg  <= e_prio;
                        cand_seq_reg   <= e_seq;
                        cand_sound_reg <= e_sound;
                    end
                end
            end
        end
        if (fin_go)
        begin
            res_reg <= fin_res;
            if (grant)
            begin
                mem_sound[grant_idx] <= cmd_reg.sound;
                mem_prio[grant_idx]  <= cmd_reg.prio;
                mem_seq[grant_idx]   <= next_seq_reg;
                mem_use[grant_idx]   <= (cmd_reg.op == vta_pkg::OP_PLAY_STREAM)
                                        ? vta_pkg::USE_STREAM : vta_pkg::USE_SAMPLE;
            end
        end
    end
endmodule
`default_nettype wire

[src/voice_track_allocator_with_stealing_top.sv]
// Channel   Handshake              Payload
// request   push / full            op, sound_id, request_priority, steal_allowed,
//                                  voice_limit, target_track
// result    empty / pop            status, granted_track, evicted_sound, stopped_tracks
// config    cfg_we                 cfg_wdata (track count)
//
// Play and stop-all requests walk the whole track table, one entry per cycle through
// the table memory read port.
// Release, finished and unused codes skip the scan and go straight to the result.
// Reset clears every track at once through per-track valid bits; no clearing pass.
// A two-entry request queue keeps taking transfers while the engine works, and the
// result register holds its transfer until popped; the engine stalls only on that.
`default_nettype none
module voice_track_allocator_with_stealing_top #(
    parameter int SEQ_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] op,
    input  wire logic [7:0] sound_id,
    input  wire logic [1:0] request_priority,
    input  wire logic       steal_allowed,
    input  wire logic [5:0] voice_limit,
    input  wire logic [5:0] target_track,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      status,
    output logic [5:0]      granted_track,
    output logic [7:0]      evicted_sound,
    output logic [6:0]      stopped_tracks,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);
    logic          cmd_valid, cmd_take, res_valid;
    vta_pkg::cmd_t cmd;
    vta_pkg::res_t res;

    // front: accept, clamp and classify requests into a short queue
    vta_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .op               (op),
        .sound_id         (sound_id),
        .request_priority (request_priority),
        .steal_allowed    (steal_allowed),
        .voice_limit      (voice_limit),
        .target_track     (target_track),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_take         (cmd_take)
    );

    // back: scan the table, pick a track, update state, post the result
    vta_back #(
        .SEQ_BITS (SEQ_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty          = !res_valid;
    assign status         = res.status;
    assign granted_track  = res.granted;
    assign evicted_sound  = res.evicted;
    assign stopped_tracks = res.stopped;
endmodule
`default_nettype wire

[src/vta_checker.sv]
`default_nettype none
module vta_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] status,
    input wire logic [5:0] granted_track,
    input wire logic [7:0] evicted_sound,
    input wire logic [6:0] stopped_tracks
);
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= vta_pkg::ST_DONE))
        else $error("result status out of range");

    a_no_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == vta_pkg::ST_LIMIT || status == vta_pkg::ST_NONE ||
                    status == vta_pkg::ST_DONE))
        |-> (granted_track == 6'd0 && evicted_sound == 8'd0))
        else $error("grant fields set without a grant");

    a_play_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != vta_pkg::ST_DONE) |-> (stopped_tracks == 7'd0))
        else $error("stop count on a play result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(granted_track)))
        else $error("waiting result changed");
endmodule

bind voice_track_allocator_with_stealing_top vta_checker u_vta_checker (.*);
`default_nettype wire

[tb/sv/tb_voice_track_allocator_with_stealing_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_voice_track_allocator_with_stealing_top;

    // Allocation outcome for one request, as the block should report it.
    typedef struct packed {
        logic [vta_pkg::STAT_BITS-1:0]  status;
        logic [vta_pkg::IDX_BITS-1:0]   granted;
        logic [vta_pkg::SOUND_BITS-1:0] evicted;
        logic [vta_pkg::CNT_BITS-1:0]   stopped;
    } grant_t;

    // Tracks the table state and queues the outcome each request must produce.
    class alloc_scoreboard;
        bit                           playing [vta_pkg::TRACKS];
        bit [vta_pkg::SOUND_BITS-1:0] snd     [vta_pkg::TRACKS];
        bit [vta_pkg::PRIO_BITS-1:0]  pri     [vta_pkg::TRACKS];
        bit [31:0]                    seq     [vta_pkg::TRACKS];
        bit [vta_pkg::USE_BITS-1:0]   usage   [vta_pkg::TRACKS];
        bit [31:0]                    next_seq;
        bit [vta_pkg::CNT_BITS-1:0]   track_count;
        grant_t                       pending[$];
        int                           errors;

        function void clear_all();
            for (int t = 0; t < vta_pkg::TRACKS; t++)
            begin
                playing[t] = 0; snd[t] = 0; pri[t] = 0; seq[t] = 0;
                usage[t] = vta_pkg::USE_NONE;
            end
            next_seq = 1;
            track_count = vta_pkg::CNT_BITS'(vta_pkg::TRACKS);
            errors = 0;
        endfunction

        // Work out the outcome of one accepted request and update the table.
        function void note_request(logic [2:0] op, logic [7:0] sound, logic [1:0] prio,
                                   logic steal, logic [5:0] limit, logic [5:0] target);
            grant_t r;
            int cnt, en, cand, lim;
            bit [vta_pkg::USE_BITS-1:0] u;
            r = '0;
            r.status = vta_pkg::ST_DONE;
            lim = (limit < 1) ? 1 : ((limit > vta_pkg::VOICE_LIMIT_MAX)
                                     ? vta_pkg::VOICE_LIMIT_MAX : int'(limit));
            if (op == vta_pkg::OP_PLAY_SAMPLE || op == vta_pkg::OP_PLAY_STREAM)
            begin
                u = (op == vta_pkg::OP_PLAY_SAMPLE) ? vta_pkg::USE_SAMPLE : vta_pkg::USE_STREAM;
                cnt = 0;
                for (int t = 0; t < vta_pkg::TRACKS; t++)
                    if (playing[t] && snd[t] == sound) cnt++;
                if (op == vta_pkg::OP_PLAY_SAMPLE && cnt >= lim)
                    r.status = vta_pkg::ST_LIMIT;
                else
                begin
                    en = (track_count < vta_pkg::TRACKS) ? int'(track_count) : vta_pkg::TRACKS;
                    cand = -1;
                    r.status = vta_pkg::ST_NONE;
                    for (int t = 0; t < en; t++)
                    begin
                        if (!playing[t])
                        begin
                            cand = t; r.status = vta_pkg::ST_IDLE; break;
                        end
                        if (!steal) continue;
                        if (u == vta_pkg::USE_STREAM && usage[t] == vta_pkg::USE_STREAM) continue;
                        if (pri[t] < prio)
                        begin
                            if (cand < 0 || pri[t] < pri[cand] ||
                                (pri[t] == pri[cand] && seq[t] < seq[cand]))
                                cand = t;
                        end
                        else if (pri[t] == prio && usage[t] != vta_pkg::USE_STREAM)
                        begin
                            if (cand < 0 || seq[t] < seq[cand]) cand = t;
                        end
                    end
                    if (cand >= 0)
                    begin
                        if (r.status != vta_pkg::ST_IDLE)
                        begin
                            r.status = vta_pkg::ST_STOLEN;
                            r.evicted = snd[cand];
                        end
                        r.granted = vta_pkg::IDX_BITS'(cand);
                        playing[cand] = 1; snd[cand] = sound; pri[cand] = prio;
                        seq[cand] = next_seq; usage[cand] = u;
                        next_seq = next_seq + 1;
                    end
                end
            end
            else if (op == vta_pkg::OP_RELEASE)
            begin
                playing[target] = 0; snd[target] = 0; pri[target] = 0;
                seq[target] = 0; usage[target] = vta_pkg::USE_NONE;
            end
            else if (op == vta_pkg::OP_FINISHED)
                playing[target] = 0;
            else if (op == vta_pkg::OP_STOP_SOUND)
            begin
                for (int t = 0; t < vta_pkg::TRACKS; t++)
                    if (snd[t] == sound && usage[t] == vta_pkg::USE_SAMPLE)
                    begin
                        if (playing[t]) r.stopped++;
                        playing[t] = 0;
                    end
            end
            pending.push_back(r);
        endfunction

        function void check_result(grant_t got);
            grant_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.granted !== want.granted)
            begin
                $error("granted_track: expected %0d, actual %0d", want.granted, got.granted);
                errors++;
            end
            if (got.evicted !== want.evicted)
            begin
                $error("evicted_sound: expected %0d, actual %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.stopped !== want.stopped)
            begin
                $error("stopped_tracks: expected %0d, actual %0d", want.stopped, got.stopped);
                errors++;
            end
        endfunction
    endclass

    logic       clk, rst_n, push, full, empty, pop, steal_allowed, cfg_we;
    logic [2:0] op, status;
    logic [7:0] sound_id, evicted_sound;
    logic [1:0] request_priority;
    logic [5:0] voice_limit, target_track, granted_track;
    logic [6:0] stopped_tracks, cfg_wdata;

    logic [6:0] int_sizes [7] = '{7'd1, 7'd3, 7'd8, 7'd64, 7'd16, 7'd5, 7'd100};

    voice_track_allocator_with_stealing_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .sound_id(sound_id), .request_priority(request_priority),
        .steal_allowed(steal_allowed), .voice_limit(voice_limit),
        .target_track(target_track), .empty(empty), .pop(pop), .status(status),
        .granted_track(granted_track), .evicted_sound(evicted_sound),
        .stopped_tracks(stopped_tracks), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    alloc_scoreboard board;
    int  cycles;
    localparam int CYCLE_LIMIT = 1500000;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Guard the whole run against a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("voice_track_allocator_with_stealing_top: mismatch");
            $finish;
        end
    end

    // Result side: drain with random stalls, sampling at the rising edge.
    initial
    begin
        int gap;
        pop = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) gap = 0;
            pop = 0;
            repeat (gap) @(negedge clk);
            pop = 1;
            // Hold pop until a transfer happens.
            do @(posedge clk); while (empty);
            board.check_result('{status, granted_track, evicted_sound, stopped_tracks});
        end
    end

    // Present one request and hold it until the transfer; stays at the negedge.
    task automatic send_request(logic [2:0] o, logic [7:0] s, logic [1:0] p, logic st,
                                logic [5:0] lim, logic [5:0] tgt, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push = 0;
            repeat (gap) @(negedge clk);
        end
        op = o; sound_id = s; request_priority = p; steal_allowed = st;
        voice_limit = lim; target_track = tgt; push = 1;
        do @(posedge clk); while (full);
        board.note_request(o, s, p, st, lim, tgt);
        @(negedge clk);
    endtask

    // Let the block go idle, then write track_count.
    task automatic set_track_count(logic [6:0] value);
        push = 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_wdata = value; cfg_we = 1;
        @(negedge clk);
        cfg_we = 0;
        board.track_count = value;
    endtask

    // Mostly plays over a small sound pool so limits, steals and stops all trigger.
    task automatic random_request(bit sparse);
        logic [2:0] o;
        logic [7:0] s;
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) o = vta_pkg::OP_PLAY_SAMPLE;
        else if (k < 65) o = vta_pkg::OP_PLAY_STREAM;
        else if (k < 77) o = vta_pkg::OP_RELEASE;
        else if (k < 89) o = vta_pkg::OP_FINISHED;
        else if (k < 96) o = vta_pkg::OP_STOP_SOUND;
        else o = 3'($urandom_range(5, 7));
        s = sparse ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
        send_request(o, s, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 3) != 0),
                     6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                     $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        board = new();
        board.clear_all();
        cycles = 0;
        rst_n = 0; push = 0; cfg_we = 0; cfg_wdata = 0;
        op = 0; sound_id = 0; request_priority = 0; steal_allowed = 0;
        voice_limit = 0; target_track = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: small table so steals and no-track come quickly.
        set_track_count(7'd2);
        send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd0, 2'd0, 1'b0, 6'd0, 6'd0, 0);
        send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd0, 2'd0, 1'b0, 6'd0, 6'd0, 0); // limit 0 as 1
        send_request(vta_pkg::OP_PLAY_STREAM, 8'd255, 2'd3, 1'b0, 6'd63, 6'd63, 0);
        send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd9, 2'd1, 1'b0, 6'd32, 6'd0, 0);  // no track
        send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd9, 2'd1, 1'b1, 6'd63, 6'd0, 0);  // steal lower
        send_request(vta_pkg::OP_PLAY_STREAM, 8'd7, 2'd3, 1'b1, 6'd1, 6'd0, 0);   // skip stream
        send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd5, 2'd1, 1'b1, 6'd1, 6'd0, 0);   // nothing to steal
        send_request(vta_pkg::OP_STOP_SOUND, 8'd5, 2'd0, 1'b0, 6'd0, 6'd0, 0);
        send_request(vta_pkg::OP_FINISHED, 8'd0, 2'd0, 1'b0, 6'd0, 6'd1, 0);
        send_request(vta_pkg::OP_RELEASE, 8'd0, 2'd0, 1'b0, 6'd0, 6'd63, 0);      // not enabled
        send_request(3'd5, 8'd1, 2'd1, 1'b1, 6'd1, 6'd1, 0);
        send_request(3'd7, 8'd0, 2'd0, 1'b0, 6'd0, 6'd0, 0);
        set_track_count(7'd0);
        send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd3, 2'd3, 1'b1, 6'd32, 6'd0, 0);
        send_request(vta_pkg::OP_PLAY_STREAM, 8'd3, 2'd3, 1'b1, 6'd32, 6'd0, 0);
        set_track_count(7'd127);                                    // clamps to table
        for (int i = 0; i < 10; i++)
            send_request(vta_pkg::OP_PLAY_SAMPLE, 8'd170, 2'd2, 1'b1, 6'd32, 6'd0, 1);
        send_request(vta_pkg::OP_STOP_SOUND, 8'd170, 2'd0, 1'b0, 6'd0, 6'd0, 0);

        // Random phases across several table sizes.
        foreach (int_sizes[i])
        begin
            set_track_count(int_sizes[i]);
            for (int n = 0; n < 250; n++)
                random_request(n % 9 == 0);
        end

        push = 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (board.errors == 0)
            $display("voice_track_allocator_with_stealing_top: match");
        else
            $display("voice_track_allocator_with_stealing_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
